// ----- hw/rtl/ttri_pkg.sv -----
package ttri_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FRAC_BITS   = 8;
	localparam int HEIGHT_W    = 16;
	localparam int POS_W       = 16;
	localparam int WIDX_W      = 16;
	localparam int CELL_W      = POS_W - FRAC_BITS;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int PROD_W      = CELL_W + CFG_W;
	localparam int IDX_W       = PROD_W + 1;
	localparam int DIFF_W      = HEIGHT_W + 1;
	localparam int WPROD_W     = DIFF_W + FRAC_BITS + 1;
	localparam int ACC_W       = WPROD_W + 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;

	localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [HEIGHT_W-1:0] data;
	} wr_t;

	typedef struct packed {
		logic                 valid;
		logic                 ok;
		logic                 lower;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
	} meta_t;

endpackage

// ----- hw/rtl/ttri_ram.sv -----
module ttri_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/ttri_front.sv -----
module ttri_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ttri_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ttri_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            start,
	output logic                            busy,
	input  logic                            opcode,
	input  logic [ttri_pkg::WIDX_W-1:0]     write_index,
	input  logic signed [ttri_pkg::HEIGHT_W-1:0] sample_height,
	input  logic [ttri_pkg::POS_W-1:0]      pos_x,
	input  logic [ttri_pkg::POS_W-1:0]      pos_y,
	output ttri_pkg::wr_t                   wr,
	output logic [ttri_pkg::ADDR_W-1:0]     raddr_base,
	output logic [ttri_pkg::ADDR_W-1:0]     raddr_diag,
	output logic [ttri_pkg::ADDR_W-1:0]     raddr_side,
	output ttri_pkg::meta_t                 meta_s2
);

	logic [ttri_pkg::CFG_W-1:0] cols_q;
	logic [ttri_pkg::CFG_W-1:0] rows_q;

	logic accept;
	logic [ttri_pkg::CELL_W-1:0]    cx;
	logic [ttri_pkg::CELL_W-1:0]    cy;
	logic                           cell_ok;

	logic                           valid_s1;
	logic                           op_s1;
	logic                           cell_ok_s1;
	logic [ttri_pkg::CELL_W-1:0]    cx_s1;
	logic [ttri_pkg::FRAC_BITS-1:0] fx_s1;
	logic [ttri_pkg::FRAC_BITS-1:0] fy_s1;
	logic [ttri_pkg::PROD_W-1:0]    prod_s1;
	logic [ttri_pkg::WIDX_W-1:0]    widx_s1;
	logic [ttri_pkg::HEIGHT_W-1:0]  wdata_s1;

	logic [ttri_pkg::IDX_W-1:0] base;
	logic [ttri_pkg::IDX_W-1:0] diag;
	logic [ttri_pkg::IDX_W-1:0] side;
	logic [31:0]                base_w;
	logic [31:0]                diag_w;
	logic [31:0]                side_w;
	logic [31:0]                widx_w;
	logic                       lower;
	logic                       diag_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= ttri_pkg::GRID_RESET;
			rows_q <= ttri_pkg::GRID_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ttri_pkg::REG_GRID_COLUMNS: cols_q <= cfg_data;
				ttri_pkg::REG_GRID_ROWS:    rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign cx = pos_x[ttri_pkg::POS_W-1:ttri_pkg::FRAC_BITS];
	assign cy = pos_y[ttri_pkg::POS_W-1:ttri_pkg::FRAC_BITS];

	// right and lower neighbours must sit inside the configured grid
	assign cell_ok = ((ttri_pkg::CFG_W'(cx) + ttri_pkg::CFG_W'(1)) < cols_q) &&
		((ttri_pkg::CFG_W'(cy) + ttri_pkg::CFG_W'(1)) < rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= opcode;
			cell_ok_s1 <= cell_ok;
			cx_s1      <= cx;
			fx_s1      <= pos_x[ttri_pkg::FRAC_BITS-1:0];
			fy_s1      <= pos_y[ttri_pkg::FRAC_BITS-1:0];
			prod_s1    <= ttri_pkg::PROD_W'(cy) * ttri_pkg::PROD_W'(cols_q);
			widx_s1    <= write_index;
			wdata_s1   <= sample_height;
		end
	end

	assign lower = fx_s1 > fy_s1;
	assign base  = ttri_pkg::IDX_W'(prod_s1) + ttri_pkg::IDX_W'(cx_s1);
	assign diag  = base + ttri_pkg::IDX_W'(cols_q) + ttri_pkg::IDX_W'(1);
	assign side  = lower ? (base + ttri_pkg::IDX_W'(1)) : (base + ttri_pkg::IDX_W'(cols_q));

	assign base_w  = 32'(base);
	assign diag_w  = 32'(diag);
	assign side_w  = 32'(side);
	assign widx_w  = 32'(widx_s1);
	assign diag_ok = diag_w < 32'(ttri_pkg::STORE_DEPTH);

	assign raddr_base = base_w[ttri_pkg::ADDR_W-1:0];
	assign raddr_diag = diag_w[ttri_pkg::ADDR_W-1:0];
	assign raddr_side = side_w[ttri_pkg::ADDR_W-1:0];

	// drop writes beyond the store
	assign wr.en   = valid_s1 && (op_s1 == ttri_pkg::OP_WRITE) &&
		(widx_w < 32'(ttri_pkg::STORE_DEPTH));
	assign wr.addr = widx_w[ttri_pkg::ADDR_W-1:0];
	assign wr.data = wdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else begin
			meta_s2.valid <= valid_s1 && (op_s1 == ttri_pkg::OP_QUERY);
			meta_s2.ok    <= cell_ok_s1 && diag_ok;
			meta_s2.lower <= lower;
			meta_s2.fx    <= fx_s1;
			meta_s2.fy    <= fy_s1;
		end
	end

endmodule

// ----- hw/rtl/ttri_interp.sv -----
module ttri_interp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ttri_pkg::meta_t                      meta_s2,
	input  logic signed [ttri_pkg::HEIGHT_W-1:0] h_base,
	input  logic signed [ttri_pkg::HEIGHT_W-1:0] h_diag,
	input  logic signed [ttri_pkg::HEIGHT_W-1:0] h_side,
	output logic                                 result_valid,
	output logic signed [ttri_pkg::HEIGHT_W-1:0] height,
	output logic                                 in_range
);

	logic signed [ttri_pkg::DIFF_W-1:0]    d_side;
	logic signed [ttri_pkg::DIFF_W-1:0]    d_diag;
	logic [ttri_pkg::FRAC_BITS-1:0]        wa;
	logic [ttri_pkg::FRAC_BITS-1:0]        wb;

	logic                                  valid_s3;
	logic                                  ok_s3;
	logic signed [ttri_pkg::WPROD_W-1:0]   pa_s3;
	logic signed [ttri_pkg::WPROD_W-1:0]   pb_s3;
	logic signed [ttri_pkg::HEIGHT_W-1:0]  h1_s3;

	logic signed [ttri_pkg::ACC_W-1:0]     acc;
	logic signed [ttri_pkg::ACC_W-1:0]     acc_sh;
	logic signed [ttri_pkg::ACC_W-1:0]     sum;

	logic                                  valid_q;
	logic                                  in_range_q;
	logic signed [ttri_pkg::HEIGHT_W-1:0]  height_q;

	assign d_side = ttri_pkg::DIFF_W'(h_side) - ttri_pkg::DIFF_W'(h_base);
	assign d_diag = ttri_pkg::DIFF_W'(h_side) - ttri_pkg::DIFF_W'(h_diag);

	// lower triangle weights the side step by fx, upper by fy
	assign wa = meta_s2.lower ? meta_s2.fx : meta_s2.fy;
	assign wb = meta_s2.lower ? meta_s2.fy : meta_s2.fx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= meta_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3 <= meta_s2.ok;
		h1_s3 <= h_base;
		pa_s3 <= signed'({1'b0, wa}) * d_side;
		pb_s3 <= signed'({1'b0, wb}) * d_diag;
	end

	assign acc    = ttri_pkg::ACC_W'(pa_s3) - ttri_pkg::ACC_W'(pb_s3);
	assign acc_sh = acc >>> ttri_pkg::FRAC_BITS;
	assign sum    = ttri_pkg::ACC_W'(h1_s3) + acc_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		in_range_q <= ok_s3;
		height_q   <= ok_s3 ? sum[ttri_pkg::HEIGHT_W-1:0] : '0;
	end

	assign result_valid = valid_q;
	assign height       = height_q;
	assign in_range     = in_range_q;

endmodule

// ----- hw/rtl/terrain_triangle_interpolator.sv -----
// Terrain height interpolator over a row-major grid of signed 16-bit samples.
// One item is taken every clock cycle (busy stays low): opcode 0 stores a
// sample, opcode 1 queries an 8.8 position. A query's result appears on
// height and in_range with result_valid high for one cycle; writes give no
// result. The store is kept as three identical synchronous RAM copies, so
// the cell corner, the diagonal corner and the side corner of the chosen
// triangle are read in the same cycle; the multiply of row by grid_columns,
// the registered RAM read, the weight multiplies and the final add each take
// one stage. The receiver cannot stall and must take every result beat as it
// appears. A query must not touch an entry that was never written.
module terrain_triangle_interpolator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [ttri_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ttri_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 opcode,
	input  logic [ttri_pkg::WIDX_W-1:0]          write_index,
	input  logic signed [ttri_pkg::HEIGHT_W-1:0] sample_height,
	input  logic [ttri_pkg::POS_W-1:0]           pos_x,
	input  logic [ttri_pkg::POS_W-1:0]           pos_y,
	output logic                                 result_valid,
	output logic signed [ttri_pkg::HEIGHT_W-1:0] height,
	output logic                                 in_range
);

	ttri_pkg::wr_t                        wr;
	ttri_pkg::meta_t                      meta_s2;
	logic [ttri_pkg::ADDR_W-1:0]          raddr_base;
	logic [ttri_pkg::ADDR_W-1:0]          raddr_diag;
	logic [ttri_pkg::ADDR_W-1:0]          raddr_side;
	logic [ttri_pkg::HEIGHT_W-1:0]        q_base;
	logic [ttri_pkg::HEIGHT_W-1:0]        q_diag;
	logic [ttri_pkg::HEIGHT_W-1:0]        q_side;

	ttri_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.write_index   (write_index),
		.sample_height (sample_height),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.wr            (wr),
		.raddr_base    (raddr_base),
		.raddr_diag    (raddr_diag),
		.raddr_side    (raddr_side),
		.meta_s2       (meta_s2)
	);

	ttri_ram #(
		.DEPTH (ttri_pkg::STORE_DEPTH),
		.WIDTH (ttri_pkg::HEIGHT_W)
	) u_ram_base (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr_base),
		.rdata (q_base)
	);

	ttri_ram #(
		.DEPTH (ttri_pkg::STORE_DEPTH),
		.WIDTH (ttri_pkg::HEIGHT_W)
	) u_ram_diag (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr_diag),
		.rdata (q_diag)
	);

	ttri_ram #(
		.DEPTH (ttri_pkg::STORE_DEPTH),
		.WIDTH (ttri_pkg::HEIGHT_W)
	) u_ram_side (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr_side),
		.rdata (q_side)
	);

	ttri_interp u_interp (
		.clk          (clk),
		.arst_n       (arst_n),
		.meta_s2      (meta_s2),
		.h_base       (signed'(q_base)),
		.h_diag       (signed'(q_diag)),
		.h_side       (signed'(q_side)),
		.result_valid (result_valid),
		.height       (height),
		.in_range     (in_range)
	);

endmodule

// ----- hw/rtl/ttri_checker.sv -----
module ttri_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          opcode,
	input logic                          result_valid,
	input logic [ttri_pkg::HEIGHT_W-1:0] height,
	input logic                          in_range
);

	logic take_query;
	logic take_write;

	assign take_query = start && !busy && (opcode == ttri_pkg::OP_QUERY);
	assign take_write = start && !busy && (opcode == ttri_pkg::OP_WRITE);

	// every accepted query yields its beat
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_query |-> ##4 result_valid)
		else $error("query beat missing");

	// writes never yield a beat
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take_write |-> ##4 !result_valid)
		else $error("beat caused by a write");

	// no beat without a matching query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(take_query, 4))
		else $error("beat with no query");

	// out-of-range beats carry zero height
	a_zero_height: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !in_range) |-> (height == '0))
		else $error("non-zero height out of range");

endmodule

bind terrain_triangle_interpolator ttri_checker u_ttri_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.opcode       (opcode),
	.result_valid (result_valid),
	.height       (height),
	.in_range     (in_range)
);

// ----- sim/tb_terrain_triangle_interpolator.sv -----
`timescale 1ns / 1ps

module tb_terrain_triangle_interpolator;
	import ttri_pkg::*;

	localparam int CLK_HIGH     = 6;
	localparam int CLK_LOW      = 6;
	localparam int RESET_CYCLES = 4;
	localparam int STALL_LIMIT  = 500;
	localparam int SETTLE_CYCLES = 12;
	localparam int FRAC_MASK    = (1 << FRAC_BITS) - 1;
	localparam int PHASES       = 10;
	localparam int OPENING_ROWS = 20;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};

	typedef struct {
		logic signed [HEIGHT_W-1:0] height;
		logic                       in_range;
	} height_result_t;

	typedef struct {
		logic                       op;
		logic [WIDX_W-1:0]          widx;
		logic signed [HEIGHT_W-1:0] sample;
		logic [POS_W-1:0]           px;
		logic [POS_W-1:0]           py;
		bit                         typed;
		logic signed [HEIGHT_W-1:0] exp_height;
		logic                       exp_in_range;
	} opening_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_write;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       start;
	logic                       busy;
	logic                       opcode;
	logic [WIDX_W-1:0]          write_index;
	logic signed [HEIGHT_W-1:0] sample_height;
	logic [POS_W-1:0]           pos_x;
	logic [POS_W-1:0]           pos_y;
	logic                       result_valid;
	logic signed [HEIGHT_W-1:0] height;
	logic                       in_range;

	// mirror of the grid store and its registers
	logic signed [HEIGHT_W-1:0] height_mem [STORE_DEPTH];
	bit                         height_written [STORE_DEPTH];
	logic [CFG_W-1:0]           grid_cols_q = GRID_RESET;
	logic [CFG_W-1:0]           grid_rows_q = GRID_RESET;

	height_result_t pending_heights [$];
	int             error_count  = 0;
	int unsigned    item_count   = 0;
	int unsigned    idle_cycles  = 0;
	bit             no_idle      = 1'b0;

	int unsigned phase_cols  [PHASES] = '{2, 1, 5, 511, 17, 256, 300, 2, 256, 64};
	int unsigned phase_rows  [PHASES] = '{2, 0, 3, 511, 130, 256, 219, 256, 2, 64};
	int unsigned phase_items [PHASES] = '{120, 30, 170, 220, 220, 220, 220, 130, 130, 220};

	// grid starts at 256 x 256; a typed expectation only where it is obvious
	opening_row_t opening_rows [OPENING_ROWS] = '{
		'{OP_WRITE, 16'd0,     HEIGHT_MAX, 16'h0000, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_WRITE, 16'd1,     HEIGHT_MIN, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0,     1'b0},
		'{OP_WRITE, 16'd256,   HEIGHT_MIN, 16'h0000, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_WRITE, 16'd257,   HEIGHT_MAX, 16'h0000, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'hFFFF,  16'sd0,     16'h0000, 16'h0000, 1'b1, HEIGHT_MAX, 1'b1},
		'{OP_QUERY, 16'd0,     16'sd0,     16'h00FF, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'h0000, 16'h00FF, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'h00FF, 16'h00FF, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'h0080, 16'h0040, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'hFF00, 16'h0000, 1'b1, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'h0000, 16'hFF00, 1'b1, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'hFFFF, 16'hFFFF, 1'b1, 16'sd0,     1'b0},
		'{OP_WRITE, 16'd65278, HEIGHT_MIN, 16'h0000, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_WRITE, 16'd65279, -16'sd1,    16'h0000, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_WRITE, 16'd65534, 16'sd1234,  16'h0000, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_WRITE, 16'd65535, HEIGHT_MAX, 16'h0000, 16'h0000, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'hFE00, 16'hFE00, 1'b1, HEIGHT_MIN, 1'b1},
		'{OP_QUERY, 16'd0,     16'sd0,     16'hFEFF, 16'hFE01, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'hFE01, 16'hFEFF, 1'b0, 16'sd0,     1'b0},
		'{OP_QUERY, 16'd0,     16'sd0,     16'hFE7F, 16'hFE7F, 1'b0, 16'sd0,     1'b0}
	};

	terrain_triangle_interpolator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.write_index   (write_index),
		.sample_height (sample_height),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.result_valid  (result_valid),
		.height        (height),
		.in_range      (in_range)
	);

	always begin
		#CLK_LOW clk = 1'b1;
		#CLK_HIGH clk = 1'b0;
	end

	// side is the right neighbour on the lower triangle, the one below on the upper
	function automatic bit locate_cell(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			output int unsigned corner, output int unsigned diag, output int unsigned side);
		int unsigned cx, cy, fx, fy;
		cx = px >> FRAC_BITS;
		cy = py >> FRAC_BITS;
		fx = px & FRAC_MASK;
		fy = py & FRAC_MASK;
		corner = cy * grid_cols_q + cx;
		diag = corner + grid_cols_q + 1;
		side = (fx > fy) ? corner + 1 : corner + grid_cols_q;
		if (cx + 1 >= grid_cols_q || cy + 1 >= grid_rows_q)
			return 1'b0;
		return diag < STORE_DEPTH;
	endfunction

	function automatic height_result_t interpolate(input logic [POS_W-1:0] px,
			input logic [POS_W-1:0] py);
		height_result_t r;
		int unsigned corner, diag, side;
		int h1, h2, h3, fx, fy, acc;
		r.height = '0;
		r.in_range = 1'b0;
		if (!locate_cell(px, py, corner, diag, side))
			return r;
		fx = px & FRAC_MASK;
		fy = py & FRAC_MASK;
		h1 = height_mem[corner];
		h2 = height_mem[side];
		h3 = height_mem[diag];
		// same form for both triangles with the fractions swapped
		if (fx > fy)
			acc = fx * (h2 - h1) - fy * (h2 - h3);
		else
			acc = fy * (h2 - h1) - fx * (h2 - h3);
		r.height = HEIGHT_W'(h1 + (acc >>> FRAC_BITS));
		r.in_range = 1'b1;
		return r;
	endfunction

	function automatic logic signed [HEIGHT_W-1:0] random_height();
		case ($urandom_range(0, 7))
			0: return HEIGHT_MIN;
			1: return HEIGHT_MAX;
			2, 3: return HEIGHT_W'($urandom_range(0, 400) - 200);
			default: return HEIGHT_W'($urandom);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic issue(input logic op, input logic [WIDX_W-1:0] widx,
			input logic signed [HEIGHT_W-1:0] sample, input logic [POS_W-1:0] px,
			input logic [POS_W-1:0] py, input bit typed, input height_result_t typed_result);
		bit taken;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		start = 1'b1;
		opcode = op;
		write_index = widx;
		sample_height = sample;
		pos_x = px;
		pos_y = py;
		do begin
			@(posedge clk);
			taken = !busy;
			if (taken) begin
				item_count++;
				if (op == OP_WRITE) begin
					height_mem[widx] = sample;
					height_written[widx] = 1'b1;
				end else begin
					pending_heights.push_back(typed ? typed_result : interpolate(px, py));
				end
			end
			@(negedge clk);
		end while (!taken);
	endtask

	// load any corner the query would read that has never been written, then issue the query
	task automatic query_filled(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
		int unsigned corner, diag, side;
		int unsigned need [3];
		height_result_t none;
		none = '{'0, 1'b0};
		if (locate_cell(px, py, corner, diag, side)) begin
			need = '{corner, diag, side};
			foreach (need[k])
				if (!height_written[need[k]])
					issue(OP_WRITE, WIDX_W'(need[k]), random_height(), POS_W'($urandom),
						POS_W'($urandom), 1'b0, none);
		end
		issue(OP_QUERY, WIDX_W'($urandom), HEIGHT_W'($urandom), px, py, 1'b0, none);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned stop_at, span, cx, cy, cmax, rmax, fx, fy;
		height_result_t none;
		none = '{'0, 1'b0};
		stop_at = item_count + count;
		while (item_count < stop_at) begin
			span = grid_cols_q * grid_rows_q;
			if (span > STORE_DEPTH)
				span = STORE_DEPTH;
			if (span == 0)
				span = 1;
			if ($urandom_range(0, 3) == 0) begin
				issue(OP_WRITE,
					WIDX_W'($urandom_range(0, 1) ? $urandom_range(0, span - 1) : $urandom),
					random_height(), POS_W'($urandom), POS_W'($urandom), 1'b0, none);
			end else if (grid_cols_q >= 2 && grid_rows_q >= 2 && $urandom_range(0, 9) < 8) begin
				cmax = (grid_cols_q - 2 > 255) ? 255 : grid_cols_q - 2;
				rmax = (grid_rows_q - 2 > 255) ? 255 : grid_rows_q - 2;
				cx = $urandom_range(0, cmax);
				cy = $urandom_range(0, rmax);
				// step onto the far edge now and then
				if ($urandom_range(0, 7) == 0)
					cx = cmax + 1;
				if ($urandom_range(0, 7) == 0)
					cy = rmax + 1;
				fx = $urandom_range(0, FRAC_MASK);
				case ($urandom_range(0, 5))
					0: fy = fx;
					1: fy = 0;
					2: fy = FRAC_MASK;
					default: fy = $urandom_range(0, FRAC_MASK);
				endcase
				query_filled(POS_W'((cx << FRAC_BITS) | fx), POS_W'((cy << FRAC_BITS) | fy));
			end else begin
				query_filled(POS_W'($urandom), POS_W'($urandom));
			end
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		case (idx)
			REG_GRID_COLUMNS: grid_cols_q = value;
			REG_GRID_ROWS:    grid_rows_q = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// wait for every outstanding result, then let trailing writes clear the pipe
	task automatic settle();
		start = 1'b0;
		while (pending_heights.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk) begin
		height_result_t want;
		if (arst_n && result_valid) begin
			if (pending_heights.size() == 0) begin
				$error("result beat with no query outstanding: height %0d in_range %0b",
					height, in_range);
				error_count++;
			end else begin
				want = pending_heights.pop_front();
				if (height !== want.height) begin
					$error("height: expected %0d, got %0d", want.height, height);
					error_count++;
				end
				if (in_range !== want.in_range) begin
					$error("in_range: expected %0b, got %0b", want.in_range, in_range);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_terrain_triangle_interpolator: done, errors");
				$finish;
			end
		end
	end

	initial begin
		height_result_t typed_result;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_GRID_COLUMNS;
		cfg_data = '0;
		start = 1'b0;
		opcode = OP_WRITE;
		write_index = '0;
		sample_height = '0;
		pos_x = '0;
		pos_y = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening_rows[i]) begin
			typed_result = '{opening_rows[i].exp_height, opening_rows[i].exp_in_range};
			issue(opening_rows[i].op, opening_rows[i].widx, opening_rows[i].sample,
				opening_rows[i].px, opening_rows[i].py, opening_rows[i].typed, typed_result);
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			// spare indices must leave the grid untouched
			if (p == 1) begin
				write_register(REG_SPARE_2, '1);
				write_register(REG_SPARE_3, CFG_W'(9'h0AA));
			end
			write_register(REG_GRID_COLUMNS, CFG_W'(phase_cols[p]));
			write_register(REG_GRID_ROWS, CFG_W'(phase_rows[p]));
			no_idle = (p == PHASES - 1);
			run_random(phase_items[p]);
		end
		settle();

		if (error_count == 0)
			$display("tb_terrain_triangle_interpolator: done, clean");
		else
			$display("tb_terrain_triangle_interpolator: done, errors");
		$finish;
	end

endmodule
